>>> rtl/core/assert_macros.svh
// Assertion macros for the touch classifier RTL.
// Included by files that check their own logic; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/ttlc_pkg.sv
// Package for the touch tap / long-press classifier.
// Holds register widths, reset values, register indexes and gesture codes.
`timescale 1ns / 1ps
`default_nettype none

package ttlc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  localparam int TAP_TIME_W   = 16;
  localparam int MOVE_LIMIT_W = 12;
  localparam int LONG_PRESS_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [TAP_TIME_W-1:0]   TAP_TIME_RST   = 16'd400;
  localparam logic [MOVE_LIMIT_W-1:0] MOVE_LIMIT_RST = 12'd30;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 16'd800;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TAP_TIME   = 2'd0,
    CFG_MOVE_LIMIT = 2'd1,
    CFG_LONG_PRESS = 2'd2
  } cfg_index_t;

  localparam logic GESTURE_TAP  = 1'b0;
  localparam logic GESTURE_LONG = 1'b1;

  typedef struct packed {
    logic [TAP_TIME_W-1:0]   tap_time_limit_ms;
    logic [MOVE_LIMIT_W-1:0] move_limit_px;
    logic [LONG_PRESS_W-1:0] long_press_ms;
  } cfg_t;

  // Flow control between the input register, the tracker and the result register.
  typedef struct packed {
    logic item_valid;
    logic take;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/ttlc_sample_if.sv
// Sample channel: valid/ready handshake carrying one polled touch sample.
// Widths follow COORD_BITS and TIME_BITS; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ttlc_sample_if #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic                  touched;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [TIME_BITS-1:0]  now_ms;
  logic                  menu_open;

  modport source (output valid, touched, pos_x, pos_y, now_ms, menu_open, input ready);
  modport sink   (input valid, touched, pos_x, pos_y, now_ms, menu_open, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ttlc_result_if.sv
// Result channel: valid/ready handshake carrying one gesture report.
// Widths follow COORD_BITS; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ttlc_result_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  gesture;
  logic [COORD_BITS-1:0] tap_x;
  logic [COORD_BITS-1:0] tap_y;

  modport source (output valid, gesture, tap_x, tap_y, input ready);
  modport sink   (input valid, gesture, tap_x, tap_y, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ttlc_cfg_regs.sv
// Configuration registers for the touch classifier.
// Uses ttlc_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module ttlc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ttlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ttlc_pkg::cfg_t                        cfg
);
  import ttlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_time_limit_ms <= TAP_TIME_RST;
      cfg.move_limit_px     <= MOVE_LIMIT_RST;
      cfg.long_press_ms     <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_TIME:   cfg.tap_time_limit_ms <= cfg_data[TAP_TIME_W-1:0];
        CFG_MOVE_LIMIT: cfg.move_limit_px     <= cfg_data[MOVE_LIMIT_W-1:0];
        CFG_LONG_PRESS: cfg.long_press_ms     <= cfg_data[LONG_PRESS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ttlc_in_stage.sv
// Input register: holds one sample until the tracker consumes it.
// Uses ttlc_pkg and the ttlc_sample_if sink modport.
`timescale 1ns / 1ps
`default_nettype none

module ttlc_in_stage #(
  parameter int COORD_BITS = ttlc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = ttlc_pkg::TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ttlc_sample_if.sink                sample,
  input  wire logic                  take,
  output logic                       item_valid,
  output logic                       touched,
  output logic [COORD_BITS-1:0]      pos_x,
  output logic [COORD_BITS-1:0]      pos_y,
  output logic [TIME_BITS-1:0]       now_ms,
  output logic                       menu_open
);
  import ttlc_pkg::*;

  logic load;

  assign sample.ready = !item_valid || take;
  assign load         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample.ready) begin
      item_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      touched   <= sample.touched;
      pos_x     <= sample.pos_x;
      pos_y     <= sample.pos_y;
      now_ms    <= sample.now_ms;
      menu_open <= sample.menu_open;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ttlc_tracker.sv
// Press tracker: keeps press state and classifies each held sample.
// Uses ttlc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttlc_tracker #(
  parameter int COORD_BITS = ttlc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = ttlc_pkg::TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ttlc_pkg::cfg_t        cfg,
  input  wire ttlc_pkg::pipe_ctl_t   ctl,
  input  wire logic                  touched,
  input  wire logic [COORD_BITS-1:0] pos_x,
  input  wire logic [COORD_BITS-1:0] pos_y,
  input  wire logic [TIME_BITS-1:0]  now_ms,
  input  wire logic                  menu_open,
  output logic                       res_valid,
  output logic                       res_gesture,
  output logic [COORD_BITS-1:0]      res_x,
  output logic [COORD_BITS-1:0]      res_y
);
  import ttlc_pkg::*;

  localparam int CMP_W = (COORD_BITS > MOVE_LIMIT_W) ? COORD_BITS : MOVE_LIMIT_W;

  logic                  press_active;
  logic                  long_press_fired;
  logic [COORD_BITS-1:0] press_start_x;
  logic [COORD_BITS-1:0] press_start_y;
  logic [TIME_BITS-1:0]  press_start_ms;

  logic                  step;
  logic                  new_press;
  logic [TIME_BITS-1:0]  held;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  near;
  logic                  long_hit;
  logic                  tap_hit;

  assign step      = ctl.item_valid && ctl.take;
  assign new_press = !menu_open && touched && !press_active;
  assign held      = now_ms - press_start_ms;
  assign dx        = (pos_x >= press_start_x) ? pos_x - press_start_x : press_start_x - pos_x;
  assign dy        = (pos_y >= press_start_y) ? pos_y - press_start_y : press_start_y - pos_y;
  assign near      = (CMP_W'(dx) < CMP_W'(cfg.move_limit_px)) &&
                     (CMP_W'(dy) < CMP_W'(cfg.move_limit_px));

  assign long_hit = !menu_open && touched && press_active && !long_press_fired &&
                    (held >= TIME_BITS'(cfg.long_press_ms)) && near;
  assign tap_hit  = !menu_open && !touched && press_active && !long_press_fired &&
                    (held < TIME_BITS'(cfg.tap_time_limit_ms)) && near;

  assign res_valid   = step && (long_hit || tap_hit);
  assign res_gesture = long_hit ? GESTURE_LONG : GESTURE_TAP;
  assign res_x       = tap_hit ? pos_x : '0;
  assign res_y       = tap_hit ? pos_y : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active     <= 1'b0;
      long_press_fired <= 1'b0;
    end else if (step) begin
      if (menu_open) begin
        press_active     <= 1'b0;
        long_press_fired <= 1'b0;
      end else if (new_press) begin
        press_active     <= 1'b1;
        long_press_fired <= 1'b0;
      end else if (touched) begin
        if (long_hit) begin
          long_press_fired <= 1'b1;
        end
      end else begin
        press_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && new_press) begin
      press_start_x  <= pos_x;
      press_start_y  <= pos_y;
      press_start_ms <= now_ms;
    end
  end

  `ASSERT_IMPLY(a_res_needs_press, clk, rst, res_valid, press_active && !long_press_fired)
  `ASSERT_NEXT(a_long_marks_fired, clk, rst, res_valid && res_gesture == GESTURE_LONG, long_press_fired && press_active)
  `ASSERT_NEXT(a_menu_clears, clk, rst, step && menu_open, !press_active && !long_press_fired)
  `ASSERT_NEXT(a_tap_ends_press, clk, rst, res_valid && res_gesture == GESTURE_TAP, !press_active)

endmodule

`default_nettype wire

>>> rtl/core/ttlc_out_stage.sv
// Result register: holds one gesture report until the sink takes it.
// Uses ttlc_pkg and the ttlc_result_if source modport.
`timescale 1ns / 1ps
`default_nettype none

module ttlc_out_stage #(
  parameter int COORD_BITS = ttlc_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load_valid,
  input  wire logic                  load_gesture,
  input  wire logic [COORD_BITS-1:0] load_x,
  input  wire logic [COORD_BITS-1:0] load_y,
  output logic                       take,
  ttlc_result_if.source              result
);
  import ttlc_pkg::*;

  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      result.gesture <= load_gesture;
      result.tap_x   <= load_x;
      result.tap_y   <= load_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/touch_tap_longpress_classifier.sv
// Touch tap / long-press classifier, top level. One touch sample is
// transferred per clock cycle while the result register is not stalled; a
// gesture report, when the sample causes one, is registered in the input
// register and then in the result register, around a single pass of
// compare logic. Most samples cause no report. A stalled result holds the
// pipeline, but the input register still takes one more sample if it is
// empty. Register writes take effect the following cycle.
// Depends on ttlc_pkg, the two channel interfaces and the ttlc_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module touch_tap_longpress_classifier #(
  parameter int COORD_BITS = ttlc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = ttlc_pkg::TIME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  ttlc_sample_if.sink                           sample,
  ttlc_result_if.source                         result,
  input  wire logic                             cfg_we,
  input  wire logic [ttlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttlc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ttlc_pkg::*;

  cfg_t                  cfg;
  pipe_ctl_t             ctl;
  logic                  take;
  logic                  item_valid;
  logic                  touched;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [TIME_BITS-1:0]  now_ms;
  logic                  menu_open;
  logic                  res_valid;
  logic                  res_gesture;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;

  assign ctl.item_valid = item_valid;
  assign ctl.take       = take;

  ttlc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttlc_in_stage #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .take       (take),
    .item_valid (item_valid),
    .touched    (touched),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .now_ms     (now_ms),
    .menu_open  (menu_open)
  );

  ttlc_tracker #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctl         (ctl),
    .touched     (touched),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .now_ms      (now_ms),
    .menu_open   (menu_open),
    .res_valid   (res_valid),
    .res_gesture (res_gesture),
    .res_x       (res_x),
    .res_y       (res_y)
  );

  ttlc_out_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (res_valid),
    .load_gesture (res_gesture),
    .load_x       (res_x),
    .load_y       (res_y),
    .take         (take),
    .result       (result)
  );

endmodule

`default_nettype wire
